// ----- hdl/pxf_pkg.sv -----
// Shared codes, types and constants for the pixel to float32 normaliser.
// No dependencies; imported by every module of the block.
package pxf_pkg;

    localparam logic [2:0] SRC_BOOL8   = 3'd0;
    localparam logic [2:0] SRC_UINT8   = 3'd1;
    localparam logic [2:0] SRC_UINT16  = 3'd2;
    localparam logic [2:0] SRC_INT16   = 3'd3;
    localparam logic [2:0] SRC_INT32   = 3'd4;
    localparam logic [2:0] SRC_FLOAT32 = 3'd5;
    localparam logic [2:0] SRC_FLOAT64 = 3'd6;

    localparam logic [2:0] FMT_MONO10  = 3'd0;
    localparam logic [2:0] FMT_MONO12  = 3'd1;
    localparam logic [2:0] FMT_MONO14  = 3'd2;
    localparam logic [2:0] FMT_MONO16  = 3'd3;
    localparam logic [2:0] FMT_BAYER16 = 3'd4;
    localparam logic [2:0] FMT_UNKNOWN = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNSUP    = 2'd1;
    localparam logic [1:0] ST_BAD_FMT  = 2'd2;

    localparam logic [0:0] REG_SRC_TYPE = 1'd0;
    localparam logic [0:0] REG_COLOR_FMT = 1'd1;

    localparam logic [2:0] SRC_RESET = SRC_UINT8;
    localparam logic [2:0] FMT_RESET = FMT_MONO16;

    // full scale is 2^n - 1; these select n
    localparam logic [2:0] FS_N8  = 3'd0;
    localparam logic [2:0] FS_N10 = 3'd1;
    localparam logic [2:0] FS_N12 = 3'd2;
    localparam logic [2:0] FS_N14 = 3'd3;
    localparam logic [2:0] FS_N16 = 3'd4;

    localparam logic [1:0] RES_DIV   = 2'd0;
    localparam logic [1:0] RES_DBL   = 2'd1;
    localparam logic [1:0] RES_PASS  = 2'd2;
    localparam logic [1:0] RES_ZERO  = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [1:0]  res_sel;
        logic        last;
        logic [31:0] pass;
    } t_ctl;

endpackage

// ----- hdl/pxf_udiv.sv -----
// Two-stage correctly rounded single-precision num / (2^n - 1), num[7:0] at n = 8.
// Uses pxf_pkg. Splits num into quotient and remainder, then uses the periodic
// binary expansion of remainder / (2^n - 1) as the fraction.
module pxf_udiv
    import pxf_pkg::*;
(
    input  logic        i_clk,
    input  logic [15:0] i_num,
    input  logic [2:0]  i_fs_sel,
    output logic [31:0] o_result
);

    logic [6:0]  n_hi, n_q;
    logic [15:0] n_lo, n_m, n_s, n_r;
    logic [47:0] n_pat;
    logic [54:0] n_x;
    logic [5:0]  n_lz;
    logic        n_zero;

    logic [54:0] r_x;
    logic [5:0]  r_lz, r_lz_b;
    logic        r_zero, r_zero_b;
    logic [23:0] r_q;
    logic        r_rb;

    logic [54:0] w_shift;
    logic [24:0] w_qr;
    logic [8:0]  w_exp;

    always_comb begin
        n_hi = '0;
        n_lo = i_num;
        n_m  = 16'hFFFF;
        case (i_fs_sel)
            FS_N8: begin
                n_lo = {8'd0, i_num[7:0]};
                n_m  = 16'd255;
            end
            FS_N10: begin
                n_hi = {1'b0, i_num[15:10]};
                n_lo = {6'd0, i_num[9:0]};
                n_m  = 16'd1023;
            end
            FS_N12: begin
                n_hi = {3'd0, i_num[15:12]};
                n_lo = {4'd0, i_num[11:0]};
                n_m  = 16'd4095;
            end
            FS_N14: begin
                n_hi = {5'd0, i_num[15:14]};
                n_lo = {2'd0, i_num[13:0]};
                n_m  = 16'd16383;
            end
            default: ;
        endcase
        // hi * 2^n + lo == hi * (2^n - 1) + (hi + lo), and hi + lo < 2 * (2^n - 1)
        n_s = n_lo + {9'd0, n_hi};
        if (n_s >= n_m) begin
            n_q = n_hi + 7'd1;
            n_r = n_s - n_m;
        end else begin
            n_q = n_hi;
            n_r = n_s;
        end
        n_pat = '0;
        case (i_fs_sel)
            FS_N8:   for (int i = 0; i < 48; i++) n_pat[47-i] = n_r[7 - (i % 8)];
            FS_N10:  for (int i = 0; i < 48; i++) n_pat[47-i] = n_r[9 - (i % 10)];
            FS_N12:  for (int i = 0; i < 48; i++) n_pat[47-i] = n_r[11 - (i % 12)];
            FS_N14:  for (int i = 0; i < 48; i++) n_pat[47-i] = n_r[13 - (i % 14)];
            default: for (int i = 0; i < 48; i++) n_pat[47-i] = n_r[15 - (i % 16)];
        endcase
        n_x    = {n_q, n_pat};
        n_zero = (n_q == 7'd0) && (n_r == 16'd0);
        n_lz   = 6'd0;
        for (int i = 0; i < 55; i++) begin
            if (n_x[i]) n_lz = 6'(54 - i);
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_lz   <= n_lz;
        r_zero <= n_zero;
    end

    assign w_shift = r_x << r_lz;

    always_ff @(posedge i_clk) begin
        r_q      <= w_shift[54:31];
        r_rb     <= w_shift[30];
        r_lz_b   <= r_lz;
        r_zero_b <= r_zero;
    end

    // a nonzero remainder never terminates, so sticky is always set: no tie case
    always_comb begin
        w_qr  = {1'b0, r_q} + {24'd0, r_rb};
        w_exp = 9'd133 - {3'd0, r_lz_b} + {8'd0, w_qr[24]};
        if (r_zero_b)
            o_result = 32'd0;
        else
            o_result = {1'b0, w_exp[7:0], w_qr[22:0]};
    end

endmodule

// ----- hdl/pxf_dnarrow.sv -----
// Two-stage float64 to float32 narrowing, round to nearest even.
// Uses pxf_pkg. Handles NaN, infinity, overflow and subnormal results.
module pxf_dnarrow
    import pxf_pkg::*;
(
    input  logic        i_clk,
    input  logic [63:0] i_bits,
    output logic [31:0] o_result
);

    logic [10:0] w_e;
    logic [52:0] n_full;
    logic [5:0]  n_sh;
    logic        n_fixed, n_sub;
    logic [31:0] n_fixed_val;
    logic [10:0] n_sh_w;

    logic [52:0] r_full;
    logic [5:0]  r_sh;
    logic        r_fixed, r_sub, r_sign;
    logic [7:0]  r_bexp;
    logic [31:0] r_fixed_val;

    logic [52:0] w_shq, w_low, w_rbv;
    logic [23:0] r_q;
    logic        r_rb, r_st, r_fixed_b, r_sub_b, r_sign_b;
    logic [7:0]  r_bexp_b;
    logic [31:0] r_fixed_val_b;

    logic [24:0] w_qr;
    logic [8:0]  w_exp;
    logic        w_inc;

    assign w_e = i_bits[62:52];

    always_comb begin
        n_full      = {1'b1, i_bits[51:0]};
        n_fixed     = 1'b0;
        n_sub       = 1'b0;
        n_fixed_val = {i_bits[63], 31'd0};
        n_sh_w      = 11'd926 - w_e;
        n_sh        = 6'd29;
        if (w_e == 11'h7FF) begin
            n_fixed = 1'b1;
            if (i_bits[51:0] == 52'd0)
                n_fixed_val = {i_bits[63], 31'h7F80_0000};
            else
                n_fixed_val = {i_bits[63], 9'h1FF, i_bits[50:29]};
        end else if (w_e >= 11'd1151) begin
            n_fixed     = 1'b1;
            n_fixed_val = {i_bits[63], 31'h7F80_0000};
        end else if (w_e < 11'd872) begin
            n_fixed = 1'b1;        // zero, double subnormal or too tiny
        end else if (w_e < 11'd897) begin
            n_sub = 1'b1;
            n_sh  = n_sh_w[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_full      <= n_full;
        r_sh        <= n_sh;
        r_fixed     <= n_fixed;
        r_sub       <= n_sub;
        r_sign      <= i_bits[63];
        r_bexp      <= 8'(w_e - 11'd896);
        r_fixed_val <= n_fixed_val;
    end

    assign w_shq = r_full >> r_sh;
    assign w_low = r_full & ((53'd1 << (r_sh - 6'd1)) - 53'd1);
    // shift of 54 puts the round bit above the hidden one: reads as zero
    assign w_rbv = r_full >> (r_sh - 6'd1);

    always_ff @(posedge i_clk) begin
        r_q           <= w_shq[23:0];
        r_rb          <= w_rbv[0];
        r_st          <= (w_low != 53'd0);
        r_fixed_b     <= r_fixed;
        r_sub_b       <= r_sub;
        r_sign_b      <= r_sign;
        r_bexp_b      <= r_bexp;
        r_fixed_val_b <= r_fixed_val;
    end

    // a carry out of the mantissa lands in the exponent; 255 gives infinity
    always_comb begin
        w_inc = r_rb & (r_st | r_q[0]);
        w_qr  = {1'b0, r_q} + {24'd0, w_inc};
        w_exp = {1'b0, r_bexp_b} + {8'd0, w_qr[24]};
        if (r_fixed_b)
            o_result = r_fixed_val_b;
        else if (r_sub_b)
            o_result = {r_sign_b, 7'd0, w_qr[23:0]};
        else if (w_exp[7:0] == 8'hFF)
            o_result = {r_sign_b, 31'h7F80_0000};
        else
            o_result = {r_sign_b, w_exp[7:0], w_qr[22:0]};
    end

endmodule

// ----- hdl/pixel_to_float32_normalizer_core.sv -----
// Top level of the pixel to float32 normaliser.
// Uses pxf_pkg, pxf_udiv and pxf_dnarrow.
//
// Command channel: a pixel transaction is taken at every rising edge with
// start high; busy is always low, so one pixel per clock is sustained.
// Result channel: o_valid strobes for one cycle with o_float_bits, o_status
// and o_last_out. The receiver cannot stall, and the block never needs it
// to: results leave in order, passing the input register, two arithmetic
// stages and the output register before o_valid rises.
// Throughput is one pixel per cycle; the divide path and the float64 path
// are each two register stages deep, fed from the input register.
// Configuration: i_cfg_valid/o_cfg_ready write i_cfg_data into register
// i_cfg_index (0 source type, 1 colour format; other indices ignored).
// o_cfg_ready is always high. Write only while no pixels are in flight.
// Reset (synchronous, active low) sets source type uint8 and colour format
// mono16 and empties the pipeline.
module pixel_to_float32_normalizer_core
    import pxf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_pixel_bits,
    input  logic        i_last_pixel,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    output logic        o_valid,
    output logic [31:0] o_float_bits,
    output logic [1:0]  o_status,
    output logic        o_last_out
);

    logic [2:0]  r_src, r_fmt;
    logic        r_v0;
    logic [63:0] r_px;
    logic        r_last0;
    logic [2:0]  r_src0, r_fmt0;

    t_ctl        n_ctl, r_ctl1, r_ctl2;
    logic [15:0] n_num;
    logic [2:0]  n_fs_sel;
    logic [31:0] w_div, w_dbl;
    logic [31:0] n_res;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= SRC_RESET;
            r_fmt <= FMT_RESET;
        end else if (i_cfg_valid && i_cfg_index[1] == 1'b0) begin
            if (i_cfg_index[0] == REG_SRC_TYPE) r_src <= i_cfg_data;
            else                                r_fmt <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else          r_v0 <= start;
        r_px    <= i_pixel_bits;
        r_last0 <= i_last_pixel;
        r_src0  <= r_src;
        r_fmt0  <= r_fmt;
    end

    always_comb begin
        n_ctl.valid   = r_v0;
        n_ctl.last    = r_last0;
        n_ctl.pass    = r_px[31:0];
        n_ctl.status  = ST_OK;
        n_ctl.res_sel = RES_ZERO;
        n_num         = {8'd0, r_px[7:0]};
        n_fs_sel      = FS_N8;
        case (r_src0)
            SRC_FLOAT32: n_ctl.res_sel = RES_PASS;
            SRC_FLOAT64: n_ctl.res_sel = RES_DBL;
            SRC_UINT8:   n_ctl.res_sel = RES_DIV;
            SRC_UINT16: begin
                n_num = r_px[15:0];
                n_ctl.res_sel = RES_DIV;
                case (r_fmt0)
                    FMT_MONO10: n_fs_sel = FS_N10;
                    FMT_MONO12: n_fs_sel = FS_N12;
                    FMT_MONO14: n_fs_sel = FS_N14;
                    FMT_MONO16, FMT_BAYER16, FMT_UNKNOWN: n_fs_sel = FS_N16;
                    default: begin
                        n_ctl.status  = ST_BAD_FMT;
                        n_ctl.res_sel = RES_ZERO;
                    end
                endcase
            end
            default: n_ctl.status = ST_UNSUP;
        endcase
    end

    pxf_udiv u_div (
        .i_clk    (i_clk),
        .i_num    (n_num),
        .i_fs_sel (n_fs_sel),
        .o_result (w_div)
    );

    pxf_dnarrow u_dbl (
        .i_clk    (i_clk),
        .i_bits   (r_px),
        .o_result (w_dbl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
            r_ctl2.valid <= 1'b0;
        end else begin
            r_ctl1.valid <= n_ctl.valid;
            r_ctl2.valid <= r_ctl1.valid;
        end
        r_ctl1.status  <= n_ctl.status;
        r_ctl1.res_sel <= n_ctl.res_sel;
        r_ctl1.last    <= n_ctl.last;
        r_ctl1.pass    <= n_ctl.pass;
        r_ctl2.status  <= r_ctl1.status;
        r_ctl2.res_sel <= r_ctl1.res_sel;
        r_ctl2.last    <= r_ctl1.last;
        r_ctl2.pass    <= r_ctl1.pass;
    end

    always_comb begin
        case (r_ctl2.res_sel)
            RES_DIV:  n_res = w_div;
            RES_DBL:  n_res = w_dbl;
            RES_PASS: n_res = r_ctl2.pass;
            default:  n_res = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_ctl2.valid;
        o_float_bits <= n_res;
        o_status     <= r_ctl2.status;
        o_last_out   <= r_ctl2.last;
    end

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for pixel_to_float32_normalizer_core.
// Depends on pxf_pkg and the RTL; directed table then random pixels checked by a predictor.
`timescale 1ns / 100ps

module testbench;
    import pxf_pkg::*;

    localparam int N_RANDOM  = 1300;
    localparam int CYCLE_CAP = 200000;
    localparam int DRAIN     = 12;

    typedef struct packed {
        logic [31:0] fbits;
        logic [1:0]  status;
        logic        last;
    } t_result;

    typedef struct {
        logic [63:0] px;
        logic        last;
        logic        known;
        t_result     res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [63:0] i_pixel_bits = '0;
    logic        i_last_pixel = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [2:0]  i_cfg_data = '0;
    logic        busy, o_cfg_ready, o_valid, o_last_out;
    logic [31:0] o_float_bits;
    logic [1:0]  o_status;

    logic [2:0] cur_src = SRC_RESET;
    logic [2:0] cur_fmt = FMT_RESET;
    t_result    pending_q[$];
    int         n_errors = 0;
    int         cycle_count = 0;

    pixel_to_float32_normalizer_core i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // correctly rounded num/den in single precision
    function automatic logic [31:0] ratio_to_single(logic [31:0] num, logic [31:0] den);
        logic [63:0] q, r;
        int k;
        k = 0;
        if (num == 0 || den == 0) return '0;
        while (k < 48 && ((64'(num) << k) / den) < (64'd1 << 23)) k++;
        q = (64'(num) << k) / den;
        r = (64'(num) << k) % den;
        if (2 * r > den || (2 * r == den && q[0])) q++;
        if (q >= (64'd1 << 24)) begin
            q = q >> 1;
            k--;
        end
        return {9'(150 - k), q[22:0]};
    endfunction

    function automatic logic [31:0] double_to_single(logic [63:0] b);
        logic [31:0] sgn;
        logic [10:0] e;
        logic [52:0] full;
        logic [63:0] q, rem, half;
        int ex, sh;
        sgn = {b[63], 31'd0};
        e = b[62:52];
        if (e == 11'h7FF) begin
            if (b[51:0] == 0) return sgn | 32'h7F80_0000;
            return sgn | 32'h7FC0_0000 | {10'd0, b[50:29]};
        end
        if (e == 0) return sgn;
        ex = int'(e) - 1023;
        if (ex >= 128) return sgn | 32'h7F80_0000;
        full = {1'b1, b[51:0]};
        if (ex >= -126) begin
            q = 64'(full) >> 29;
            rem = 64'(full[28:0]);
            half = 64'd1 << 28;
            if (rem > half || (rem == half && q[0])) q++;
            if (q >= (64'd1 << 24)) begin
                q = q >> 1;
                ex++;
            end
            if (ex >= 128) return sgn | 32'h7F80_0000;
            return sgn | {1'b0, 8'(ex + 127), q[22:0]};
        end
        sh = -ex - 97;
        if (sh > 54) return sgn;
        q = 64'(full) >> sh;
        rem = 64'(full) & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q++;
        return sgn | q[31:0];
    endfunction

    function automatic t_result normalise_pixel(logic [63:0] px, logic last);
        t_result r;
        logic [31:0] fs;
        r = '{fbits: '0, status: ST_OK, last: last};
        case (cur_src)
            SRC_FLOAT32: r.fbits = px[31:0];
            SRC_FLOAT64: r.fbits = double_to_single(px);
            SRC_UINT8:   r.fbits = ratio_to_single({24'd0, px[7:0]}, 32'd255);
            SRC_UINT16: begin
                case (cur_fmt)
                    FMT_MONO10: fs = 32'd1023;
                    FMT_MONO12: fs = 32'd4095;
                    FMT_MONO14: fs = 32'd16383;
                    FMT_MONO16, FMT_BAYER16, FMT_UNKNOWN: fs = 32'd65535;
                    default: r.status = ST_BAD_FMT;
                endcase
                if (r.status == ST_OK) r.fbits = ratio_to_single({16'd0, px[15:0]}, fs);
            end
            default: r.status = ST_UNSUP;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("FAIL pixel_to_float32_normalizer_core");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", o_float_bits, '0);
            end else begin
                w = pending_q.pop_front();
                if (o_float_bits !== w.fbits) report_mismatch("float_bits", o_float_bits, w.fbits);
                if (o_status !== w.status) report_mismatch("status", 32'(o_status), 32'(w.status));
                if (o_last_out !== w.last) report_mismatch("last_out", 32'(o_last_out), 32'(w.last));
            end
        end
    end

    // one pixel transaction; expectation queued at the accepting edge
    task automatic send_pixel(logic [63:0] px, logic last, logic known, t_result res);
        t_result w;
        start <= 1'b1;
        i_pixel_bits <= px;
        i_last_pixel <= last;
        do @(posedge i_clk); while (busy);
        w = known ? res : normalise_pixel(px, last);
        pending_q.push_back(w);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [2:0] val);
        idle_cycles(1);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == 2'(REG_SRC_TYPE)) cur_src = val;
        else if (idx == 2'(REG_COLOR_FMT)) cur_fmt = val;
    endtask

    function automatic logic [63:0] random_word();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v[62:52] = 11'h7FF;
            1: v[62:52] = 11'h000;
            2: v[62:52] = 11'(1023 - 126 - $urandom_range(0, 30));
            3: v[62:52] = 11'(1023 + 127 + $urandom_range(0, 1));
            4: v[28:0] = 29'h1000_0000;
            default: ;
        endcase
        return v;
    endfunction

    t_row dir_rows[$];
    t_result z;

    initial begin
        int burst, idx;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: uint8 / mono16
        dir_rows = '{
            '{64'h0, 1'b0, 1'b1, '{32'h0, ST_OK, 1'b0}},
            '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, '{32'h3F80_0000, ST_OK, 1'b1}},
            '{64'h80, 1'b0, 1'b0, z},
            '{64'h01, 1'b1, 1'b0, z}
        };
        foreach (dir_rows[i]) send_pixel(dir_rows[i].px, dir_rows[i].last,
                                          dir_rows[i].known, dir_rows[i].res);
        write_reg(2'(REG_SRC_TYPE), SRC_UINT16);
        for (int f = 0; f < 8; f++) begin
            write_reg(2'(REG_COLOR_FMT), 3'(f));
            send_pixel(64'hFFFF, 1'b1, 1'b0, z);
            send_pixel(64'h3FF, 1'b0, 1'b0, z);
        end
        write_reg(2'(REG_SRC_TYPE), SRC_FLOAT64);
        dir_rows = '{
            '{64'h7FF0_0000_0000_0000, 1'b0, 1'b1, '{32'h7F80_0000, ST_OK, 1'b0}},
            '{64'hFFF0_0000_0000_0000, 1'b1, 1'b1, '{32'hFF80_0000, ST_OK, 1'b1}},
            '{64'hFFF8_0000_2000_0000, 1'b0, 1'b0, z},
            '{64'h7FF0_0000_0000_0001, 1'b0, 1'b0, z},
            '{64'h8000_0000_0000_0001, 1'b0, 1'b1, '{32'h8000_0000, ST_OK, 1'b0}},
            '{64'h47EF_FFFF_F000_0000, 1'b0, 1'b0, z},
            '{64'h3690_0000_0000_0000, 1'b0, 1'b0, z},
            '{64'h3680_0000_0000_0001, 1'b0, 1'b0, z},
            '{64'h3FF0_0000_1000_0000, 1'b1, 1'b0, z}
        };
        foreach (dir_rows[i]) send_pixel(dir_rows[i].px, dir_rows[i].last,
                                          dir_rows[i].known, dir_rows[i].res);
        write_reg(2'(REG_SRC_TYPE), SRC_FLOAT32);
        send_pixel(64'hDEAD_BEEF_1234_5678, 1'b0, 1'b1, '{32'h1234_5678, ST_OK, 1'b0});
        for (int s = 0; s < 8; s++) begin
            if (s inside {SRC_BOOL8, SRC_INT16, SRC_INT32, 7}) begin
                write_reg(2'(REG_SRC_TYPE), 3'(s));
                send_pixel(64'h1, 1'b1, 1'b1, '{32'h0, ST_UNSUP, 1'b1});
            end
        end
        write_reg(2'd3, 3'd5);

        // random phases, each with its own setting
        idx = 0;
        while (idx < N_RANDOM) begin
            write_reg(2'(REG_SRC_TYPE), ($urandom_range(0, 3) != 0) ?
                      3'(SRC_UINT8 + $urandom_range(0, 1) + 4 * $urandom_range(0, 1))
                      : 3'($urandom));
            if ($urandom_range(0, 1)) write_reg(2'(REG_COLOR_FMT), 3'($urandom));
            repeat ($urandom_range(4, 12)) begin
                burst = $urandom_range(1, 16);
                repeat (burst) begin
                    if (idx < N_RANDOM) begin
                        send_pixel(random_word(), 1'($urandom), 1'b0, z);
                        idx++;
                    end
                end
                if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
            end
        end
        idle_cycles(1);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS pixel_to_float32_normalizer_core");
        end else begin
            $display("FAIL pixel_to_float32_normalizer_core");
        end
        $finish;
    end
endmodule
